[rtl/smvm_pkg.sv]
// Shared constants, codes and types for the sparse matrix-vector multiplier.
package smvm_pkg;

    // Storage sizes.
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = 1024;

    // Widths that follow from the storage sizes.
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int LEN_W  = 7;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LINK_W = 11;

    // Arithmetic widths: signed Q16.16 operands, full product, row accumulator.
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int ACC_W   = TERM_W + ADDR_W + 1;
    localparam int STORE_W = VAL_W + LINK_W;

    // Operation codes carried in the input tuser.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_WR_STORE = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_VEC   = 2'd1;
    localparam logic [OP_W-1:0] OP_START    = 2'd2;

    // Input tdata layout, lowest field first.
    localparam int IN_ADDR_LSB = 0;
    localparam int IN_SVAL_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_LINK_LSB = IN_SVAL_LSB + VAL_W;
    localparam int IN_VIDX_LSB = IN_LINK_LSB + LINK_W;
    localparam int IN_VVAL_LSB = IN_VIDX_LSB + ROW_W;
    localparam int IN_BITS     = IN_VVAL_LSB + VAL_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest field first; tuser holds saturated, mismatch.
    localparam int OUT_ROW_LSB  = 0;
    localparam int OUT_PROD_LSB = OUT_ROW_LSB + ROW_W;
    localparam int OUT_BITS     = OUT_PROD_LSB + VAL_W;
    localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W    = 2;
    localparam int USER_SAT     = 0;
    localparam int USER_MISM    = 1;

    // Control word from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic mul_en;
        logic zero_b;
    } t_mac_ctrl;

endpackage

[rtl/smvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/smvm_mac.sv]
// Shared multiply-accumulate unit with 32-bit saturation of the row sum.
module smvm_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smvm_pkg::t_mac_ctrl             i_ctrl,
    input  logic signed [smvm_pkg::VAL_W-1:0] i_op_a,
    input  logic signed [smvm_pkg::VAL_W-1:0] i_op_b,
    output logic [smvm_pkg::VAL_W-1:0]      o_result,
    output logic                            o_sat
);
    import smvm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  op_b;
    logic [ACC_W-1:0]         term;
    logic [ACC_W-VAL_W:0]     acc_hi;
    logic                     hi_ones;
    logic                     hi_zeros;

    // A column outside the vector contributes nothing.
    assign op_b = i_ctrl.zero_b ? '0 : i_op_b;

    // Product register; the valid flag is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * op_b;
        end
    end

    // Dropping the low fraction bits of a signed product rounds toward minus infinity.
    assign term = {{(ACC_W-TERM_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:FRAC_W]};

    // Accumulator: exact row sum, cleared at the start of each row.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + $signed(term);
        end
    end

    // Clamp to the signed 32-bit range when the upper bits are not a pure sign extension.
    assign acc_hi   = r_acc[ACC_W-1:VAL_W-1];
    assign hi_ones  = &acc_hi;
    assign hi_zeros = ~|acc_hi;

    always_comb begin
        if (hi_ones || hi_zeros) begin
            o_result = r_acc[VAL_W-1:0];
            o_sat    = 1'b0;
        end else begin
            o_result = r_acc[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            o_sat    = 1'b1;
        end
    end

endmodule

[rtl/sparse_matrix_vector_multiply_top.sv]
// Top level of the row-indexed sparse matrix-vector multiplier.
//
// Input words arrive on s_axis; tuser carries the operation. A store-write
// word loads one slot of the matrix store (value and link), a vector-write
// word loads one vector element; each keeps tready up and gives no output.
// A start word makes the block walk the matrix and send one output word per
// row on m_axis, with tlast on the final row, or a single word with the
// mismatch flag and tlast set when link slot 0 is not the row count plus one.
// The row count is written on the cfg channel while the block is idle.
// During a multiply s_axis_tready stays low. A start first checks slot 0,
// then each row runs the diagonal states and then one fetch, column and
// multiply pass per off-diagonal term, through the single shared multiplier
// and the one read port of the matrix store, which is read once per term.
// The output register holds a finished word while the receiver stalls, and
// the sequencer waits before loading the next one. Synchronous reset idles
// the block, empties the output register and sets the row count to one; the
// store and vector contents are not cleared.
module sparse_matrix_vector_multiply_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: row count.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [smvm_pkg::LEN_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // store_address, store_value, store_link, vector_index, vector_value, zero pad
    input  logic [smvm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [smvm_pkg::OP_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // row_index, product_value, zero pad
    output logic [smvm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // saturated, mismatch
    output logic [smvm_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    import smvm_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_CHK    = 4'd1;
    localparam logic [ST_W-1:0] S_DIAG_A = 4'd2;
    localparam logic [ST_W-1:0] S_DIAG_B = 4'd3;
    localparam logic [ST_W-1:0] S_END    = 4'd4;
    localparam logic [ST_W-1:0] S_FETCH  = 4'd5;
    localparam logic [ST_W-1:0] S_COL    = 4'd6;
    localparam logic [ST_W-1:0] S_MUL    = 4'd7;
    localparam logic [ST_W-1:0] S_EMIT   = 4'd8;
    localparam logic [ST_W-1:0] S_ERR    = 4'd9;

    logic [ST_W-1:0]      r_state, n_state;
    logic [LEN_W-1:0]     r_vec_len;
    logic [LEN_W-1:0]     r_n, n_n;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [LINK_W-1:0]    r_k, n_k;
    logic [LINK_W-1:0]    r_end, n_end;
    logic [VAL_W-1:0]     r_val, n_val;
    logic                 r_col_ok, n_col_ok;
    logic                 r_m_vld, n_m_vld;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;
    logic [M_TUSER_W-1:0] r_m_user, n_m_user;
    logic                 r_m_last, n_m_last;

    logic                 in_fire;
    logic [OP_W-1:0]      in_op;
    logic [ADDR_W-1:0]    in_addr;
    logic [VAL_W-1:0]     in_sval;
    logic [LINK_W-1:0]    in_link;
    logic [ROW_W-1:0]     in_vidx;
    logic [VAL_W-1:0]     in_vval;

    logic                 st_we;
    logic                 st_re;
    logic [ADDR_W-1:0]    st_raddr;
    logic [STORE_W-1:0]   st_rdata;
    logic [VAL_W-1:0]     st_val;
    logic [LINK_W-1:0]    st_link;
    logic                 vec_we;
    logic                 vec_re;
    logic [ROW_W-1:0]     vec_raddr;
    logic [VAL_W-1:0]     vec_rdata;

    t_mac_ctrl            mac_ctrl;
    logic [VAL_W-1:0]     mac_a;
    logic [VAL_W-1:0]     mac_result;
    logic                 mac_sat;

    logic                 out_free;
    logic [LEN_W-1:0]     row_nxt;
    logic [LEN_W-1:0]     used_rows;
    logic [LINK_W-1:0]    end_clamped;

    // Field unpacking of the input word.
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_op   = s_axis_tuser;
    assign in_addr = s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
    assign in_sval = s_axis_tdata[IN_SVAL_LSB +: VAL_W];
    assign in_link = s_axis_tdata[IN_LINK_LSB +: LINK_W];
    assign in_vidx = s_axis_tdata[IN_VIDX_LSB +: ROW_W];
    assign in_vval = s_axis_tdata[IN_VVAL_LSB +: VAL_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);

    // Matrix store: value in the low bits, link above it.
    assign st_we  = in_fire && (in_op == OP_WR_STORE);
    assign st_val  = st_rdata[VAL_W-1:0];
    assign st_link = st_rdata[STORE_W-1:VAL_W];

    smvm_ram #(
        .WIDTH(STORE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (in_addr),
        .i_wr_data ({in_link, in_sval}),
        .i_rd_en   (st_re),
        .i_rd_addr (st_raddr),
        .o_rd_data (st_rdata)
    );

    assign vec_we = in_fire && (in_op == OP_WR_VEC);

    smvm_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ROWS)
    ) u_vector (
        .i_clk     (i_clk),
        .i_wr_en   (vec_we),
        .i_wr_addr (in_vidx),
        .i_wr_data (in_vval),
        .i_rd_en   (vec_re),
        .i_rd_addr (vec_raddr),
        .o_rd_data (vec_rdata)
    );

    smvm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_op_a   (mac_a),
        .i_op_b   (vec_rdata),
        .o_result (mac_result),
        .o_sat    (mac_sat)
    );

    // Helper values for the sequencer.
    assign out_free = !r_m_vld || m_axis_tready;
    assign row_nxt  = {1'b0, r_row} + LEN_W'(1);
    assign end_clamped = (st_link > LINK_W'(STORE_DEPTH)) ? LINK_W'(STORE_DEPTH) : st_link;

    // A row count of zero acts as one, and one above the limit acts as the limit.
    always_comb begin
        if (r_vec_len == '0) begin
            used_rows = LEN_W'(1);
        end else if (r_vec_len > LEN_W'(MAX_ROWS)) begin
            used_rows = LEN_W'(MAX_ROWS);
        end else begin
            used_rows = r_vec_len;
        end
    end

    // Read ports and unit control by state.
    always_comb begin
        st_re     = 1'b0;
        st_raddr  = '0;
        vec_re    = 1'b0;
        vec_raddr = st_link[ROW_W-1:0];
        mac_ctrl  = '0;
        mac_a     = r_val;
        unique case (r_state)
            S_IDLE: begin
                st_re = 1'b1;
            end
            S_DIAG_A: begin
                st_re        = 1'b1;
                st_raddr     = ADDR_W'(r_row);
                vec_re       = 1'b1;
                vec_raddr    = r_row;
                mac_ctrl.clr = 1'b1;
            end
            S_DIAG_B: begin
                st_re           = 1'b1;
                st_raddr        = ADDR_W'(row_nxt);
                mac_ctrl.mul_en = 1'b1;
                mac_a           = st_val;
            end
            S_FETCH: begin
                st_re    = (r_k < r_end);
                st_raddr = r_k[ADDR_W-1:0];
            end
            S_COL: begin
                vec_re = 1'b1;
            end
            S_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.zero_b = !r_col_ok;
            end
            S_CHK, S_END, S_EMIT, S_ERR: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and output register.
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_row    = r_row;
        n_k      = r_k;
        n_end    = r_end;
        n_val    = r_val;
        n_col_ok = r_col_ok;
        n_m_vld  = r_m_vld && !m_axis_tready;
        n_m_data = r_m_data;
        n_m_user = r_m_user;
        n_m_last = r_m_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (in_op == OP_START)) begin
                    n_n     = used_rows;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_row = '0;
                if (st_link != ({{(LINK_W-LEN_W){1'b0}}, r_n} + LINK_W'(1))) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DIAG_A;
                end
            end
            S_DIAG_A: begin
                n_state = S_DIAG_B;
            end
            S_DIAG_B: begin
                n_k     = st_link;
                n_state = S_END;
            end
            S_END: begin
                // No off-diagonal terms when the end slot lies past the store.
                if (int'(row_nxt) >= STORE_DEPTH) begin
                    n_end = '0;
                end else begin
                    n_end = end_clamped;
                end
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_k < r_end) begin
                    n_k     = r_k + LINK_W'(1);
                    n_state = S_COL;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_COL: begin
                n_val    = st_val;
                n_col_ok = (st_link < LINK_W'(MAX_ROWS));
                n_state  = S_MUL;
            end
            S_MUL: begin
                n_state = S_FETCH;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_m_vld  = 1'b1;
                    n_m_data = '0;
                    n_m_data[OUT_ROW_LSB +: ROW_W]  = r_row;
                    n_m_data[OUT_PROD_LSB +: VAL_W] = mac_result;
                    n_m_user = '0;
                    n_m_user[USER_SAT] = mac_sat;
                    n_m_last = (row_nxt == r_n);
                    if (row_nxt == r_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = row_nxt[ROW_W-1:0];
                        n_state = S_DIAG_A;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_m_vld  = 1'b1;
                    n_m_data = '0;
                    n_m_user = '0;
                    n_m_user[USER_MISM] = 1'b1;
                    n_m_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Registers: control state reset, payload free-running.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vec_len <= LEN_W'(1);
            r_m_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m_vld <= n_m_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vec_len <= i_cfg_data;
            end
        end
        r_n      <= n_n;
        r_row    <= n_row;
        r_k      <= n_k;
        r_end    <= n_end;
        r_val    <= n_val;
        r_col_ok <= n_col_ok;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule

[rtl/smvm_checker.sv]
// Port-level checks for the sparse matrix-vector multiplier, bound to the top level.
module smvm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [smvm_pkg::OP_W-1:0]      s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [smvm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic [smvm_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input  logic                           m_axis_tlast
);
    import smvm_pkg::*;

    // A stalled output word holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The error word ends the run and carries no product.
    a_mism_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_MISM] |->
            m_axis_tlast && !m_axis_tuser[USER_SAT] && (m_axis_tdata == '0))
        else $error("mismatch word malformed");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A start word makes the block busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START) |=> !s_axis_tready)
        else $error("input ready right after start");

    // After a load word the input stays ready.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
            && ((s_axis_tuser == OP_WR_STORE) || (s_axis_tuser == OP_WR_VEC))
            |=> s_axis_tready)
        else $error("input not ready after a load word");

endmodule

bind sparse_matrix_vector_multiply_top smvm_checker u_smvm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
